// File: rtl/frar_pkg.sv
// Shared types and constants of the framed register access responder.
// Used by every module of the block; depends on nothing.
package frar_pkg;

    // Parameter defaults
    localparam int MAX_DATA_DEF      = 16;
    localparam int PARAM_ENTRIES_DEF = 64;
    localparam int LIVE_ENTRIES_DEF  = 64;

    // Command bytes plus the first five data bytes are kept per frame
    localparam int HEAD_DEPTH = 6;

    // Shortest frame length a read or a write needs
    localparam int MIN_RD_LEN = 2;
    localparam int MIN_WR_LEN = 6;

    // Configuration register reset values
    localparam logic [7:0] START_RST = 8'hAA;
    localparam logic [7:0] END_RST   = 8'h55;
    localparam logic [7:0] ACK_RST   = 8'h06;
    localparam logic [7:0] NAK_RST   = 8'h15;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NAK   = 2'd3;

    // Command codes
    localparam logic [7:0] CMD_RD_PARAM = 8'h01;
    localparam logic [7:0] CMD_WR_PARAM = 8'h02;
    localparam logic [7:0] CMD_RD_LIVE  = 8'h03;
    localparam logic [7:0] CMD_WR_LIVE  = 8'h04;

    // LEN byte of a reply without and with a four-byte value
    localparam logic [7:0] LEN_SHORT = 8'd1;
    localparam logic [7:0] LEN_READ  = 8'd5;

    // Reply request from the parser to the reply generator
    typedef struct packed {
        logic valid;
        logic ack;
        logic has_data;
    } rsp_req_t;

    // Table access from the parser to the table store
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic        sel_live;
        logic [7:0]  id;
        logic [31:0] wdata;
    } tbl_req_t;

endpackage

// File: rtl/frar_parser.sv
// Frame parser: hunts the start byte, takes length, body, check and end byte,
// and decodes the command. Depends on frar_pkg.
module frar_parser #(
    parameter int MAX_DATA = frar_pkg::MAX_DATA_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rx_valid,
    output logic               rx_ready,
    input  logic [7:0]         rx_byte,
    input  logic [7:0]         start_byte,
    input  logic [7:0]         end_byte,
    input  logic               busy,
    output frar_pkg::rsp_req_t rsp_req,
    output frar_pkg::tbl_req_t tbl_req
);

    localparam int CNT_W      = $clog2(MAX_DATA + 3);
    localparam int HEAD_IDX_W = $clog2(frar_pkg::HEAD_DEPTH);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEN,
        PH_BODY
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       run_chk_reg, run_chk_next;
    logic [7:0]       held_chk_reg, held_chk_next;
    logic [7:0]       head_reg [frar_pkg::HEAD_DEPTH];

    logic final_byte;
    logic take;
    logic len_ok;

    // The end byte of a frame waits while the previous reply is still going out
    assign final_byte = (phase_reg == PH_BODY) && (cnt_reg > len_reg);
    assign rx_ready   = !(final_byte && busy);
    assign take       = rx_valid && rx_ready;
    assign len_ok     = (rx_byte != 8'd0) && (rx_byte <= 8'(MAX_DATA + 1));

    always_comb begin
        phase_next    = phase_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        run_chk_next  = run_chk_reg;
        held_chk_next = held_chk_reg;
        if (take) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (rx_byte == start_byte) begin
                        cnt_next   = '0;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (!len_ok) begin
                        phase_next = PH_IDLE;
                    end else begin
                        len_next     = rx_byte[CNT_W-1:0];
                        cnt_next     = '0;
                        run_chk_next = rx_byte;
                        phase_next   = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (cnt_reg < len_reg) begin
                        cnt_next     = cnt_reg + 1'b1;
                        run_chk_next = run_chk_reg ^ rx_byte;
                    end else if (cnt_reg == len_reg) begin
                        cnt_next      = cnt_reg + 1'b1;
                        held_chk_next = rx_byte;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            len_reg      <= '0;
            cnt_reg      <= '0;
            run_chk_reg  <= '0;
            held_chk_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            len_reg      <= len_next;
            cnt_reg      <= cnt_next;
            run_chk_reg  <= run_chk_next;
            held_chk_reg <= held_chk_next;
        end
    end

    // Keep the command byte and the first data bytes of the frame
    always_ff @(posedge aclk) begin
        if (take && phase_reg == PH_BODY && cnt_reg < len_reg
                && cnt_reg < CNT_W'(frar_pkg::HEAD_DEPTH)) begin
            head_reg[cnt_reg[HEAD_IDX_W-1:0]] <= rx_byte;
        end
    end

    // Decode the command when a good end byte closes the frame
    always_comb begin
        rsp_req          = '0;
        tbl_req          = '0;
        tbl_req.id       = head_reg[1];
        tbl_req.wdata    = {head_reg[2], head_reg[3], head_reg[4], head_reg[5]};
        tbl_req.sel_live = (head_reg[0] == frar_pkg::CMD_RD_LIVE)
                        || (head_reg[0] == frar_pkg::CMD_WR_LIVE);
        if (take && final_byte && rx_byte == end_byte) begin
            rsp_req.valid = 1'b1;
            if (held_chk_reg == run_chk_reg) begin
                unique case (head_reg[0]) inside
                    frar_pkg::CMD_RD_PARAM, frar_pkg::CMD_RD_LIVE: begin
                        if (len_reg >= CNT_W'(frar_pkg::MIN_RD_LEN)) begin
                            rsp_req.ack      = 1'b1;
                            rsp_req.has_data = 1'b1;
                            tbl_req.rd       = 1'b1;
                        end
                    end
                    frar_pkg::CMD_WR_PARAM, frar_pkg::CMD_WR_LIVE: begin
                        if (len_reg >= CNT_W'(frar_pkg::MIN_WR_LEN)) begin
                            rsp_req.ack = 1'b1;
                            tbl_req.wr  = 1'b1;
                        end
                    end
                    default: rsp_req.ack = 1'b0;
                endcase
            end
        end
    end

endmodule

// File: rtl/frar_tables.sv
// Parameter and live word tables with per-entry valid bits and registered reads.
// Depends on frar_pkg.
module frar_tables #(
    parameter int PARAM_ENTRIES = frar_pkg::PARAM_ENTRIES_DEF,
    parameter int LIVE_ENTRIES  = frar_pkg::LIVE_ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  frar_pkg::tbl_req_t tbl_req,
    output logic [31:0]        rd_data
);

    localparam int PIDX_W = (PARAM_ENTRIES > 1) ? $clog2(PARAM_ENTRIES) : 1;
    localparam int LIDX_W = (LIVE_ENTRIES > 1) ? $clog2(LIVE_ENTRIES) : 1;

    logic [31:0]              pmem [PARAM_ENTRIES];
    logic [31:0]              lmem [LIVE_ENTRIES];
    logic [PARAM_ENTRIES-1:0] pval_reg;
    logic [LIVE_ENTRIES-1:0]  lval_reg;

    logic [31:0] p_rd_reg;
    logic [31:0] l_rd_reg;
    logic        zero_reg;
    logic        live_reg;

    logic              p_hit, l_hit;
    logic [PIDX_W-1:0] pidx;
    logic [LIDX_W-1:0] lidx;

    // Ids past the end of a table read zero and drop writes
    assign p_hit = {1'b0, tbl_req.id} < 9'(PARAM_ENTRIES);
    assign l_hit = {1'b0, tbl_req.id} < 9'(LIVE_ENTRIES);
    assign pidx  = p_hit ? tbl_req.id[PIDX_W-1:0] : '0;
    assign lidx  = l_hit ? tbl_req.id[LIDX_W-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pval_reg <= '0;
            lval_reg <= '0;
        end else if (tbl_req.wr) begin
            if (!tbl_req.sel_live && p_hit) pval_reg[pidx] <= 1'b1;
            if (tbl_req.sel_live && l_hit)  lval_reg[lidx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_req.wr && !tbl_req.sel_live && p_hit) pmem[pidx] <= tbl_req.wdata;
    end

    always_ff @(posedge aclk) begin
        if (tbl_req.wr && tbl_req.sel_live && l_hit) lmem[lidx] <= tbl_req.wdata;
    end

    always_ff @(posedge aclk) begin
        if (tbl_req.rd) begin
            p_rd_reg <= pmem[pidx];
            l_rd_reg <= lmem[lidx];
            live_reg <= tbl_req.sel_live;
            zero_reg <= tbl_req.sel_live ? !(l_hit && lval_reg[lidx])
                                         : !(p_hit && pval_reg[pidx]);
        end
    end

    assign rd_data = zero_reg ? 32'd0 : (live_reg ? l_rd_reg : p_rd_reg);

endmodule

// File: rtl/frar_reply.sv
// Reply generator: sends one reply frame a byte at a time through an output register.
// Depends on frar_pkg.
module frar_reply (
    input  logic               aclk,
    input  logic               aresetn,
    input  frar_pkg::rsp_req_t rsp_req,
    input  logic [31:0]        rd_data,
    input  logic [7:0]         start_byte,
    input  logic [7:0]         end_byte,
    input  logic [7:0]         ack_code,
    input  logic [7:0]         nak_code,
    output logic               busy,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_byte,
    output logic               m_last
);

    localparam logic [3:0] POS_START = 4'd0;
    localparam logic [3:0] POS_LEN   = 4'd1;
    localparam logic [3:0] POS_CODE  = 4'd2;
    localparam logic [3:0] POS_D0    = 4'd3;
    localparam logic [3:0] POS_D1    = 4'd4;
    localparam logic [3:0] POS_D2    = 4'd5;
    localparam logic [3:0] POS_D3    = 4'd6;
    localparam logic [3:0] POS_CHK   = 4'd7;
    localparam logic [3:0] POS_END   = 4'd8;

    logic       active_reg, active_next;
    logic [3:0] idx_reg, idx_next;
    logic       ack_reg, ack_next;
    logic       has_data_reg, has_data_next;
    logic [7:0] chk_reg, chk_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg, m_byte_next;
    logic       m_last_reg, m_last_next;

    logic [3:0] pos;
    logic [7:0] cur_byte;
    logic       push;

    // Replies without a value skip the four data positions
    assign pos  = (!has_data_reg && idx_reg >= POS_D0) ? idx_reg + 4'd4 : idx_reg;
    assign push = active_reg && (!m_valid_reg || m_ready);

    always_comb begin
        unique case (pos)
            POS_START: cur_byte = start_byte;
            POS_LEN:   cur_byte = has_data_reg ? frar_pkg::LEN_READ : frar_pkg::LEN_SHORT;
            POS_CODE:  cur_byte = ack_reg ? ack_code : nak_code;
            POS_D0:    cur_byte = rd_data[31:24];
            POS_D1:    cur_byte = rd_data[23:16];
            POS_D2:    cur_byte = rd_data[15:8];
            POS_D3:    cur_byte = rd_data[7:0];
            POS_CHK:   cur_byte = chk_reg;
            POS_END:   cur_byte = end_byte;
            default:   cur_byte = end_byte;
        endcase
    end

    always_comb begin
        active_next   = active_reg;
        idx_next      = idx_reg;
        ack_next      = ack_reg;
        has_data_next = has_data_reg;
        chk_next      = chk_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_byte_next   = m_byte_reg;
        m_last_next   = m_last_reg;
        if (rsp_req.valid) begin
            active_next   = 1'b1;
            idx_next      = '0;
            ack_next      = rsp_req.ack;
            has_data_next = rsp_req.has_data;
            chk_next      = '0;
        end else if (push) begin
            idx_next     = idx_reg + 1'b1;
            m_valid_next = 1'b1;
            m_byte_next  = cur_byte;
            m_last_next  = (pos == POS_END);
            if (pos == POS_END) active_next = 1'b0;
            if (pos >= POS_LEN && pos <= POS_D3) chk_next = chk_reg ^ cur_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            idx_reg      <= '0;
            ack_reg      <= 1'b0;
            has_data_reg <= 1'b0;
            chk_reg      <= '0;
            m_valid_reg  <= 1'b0;
            m_last_reg   <= 1'b0;
        end else begin
            active_reg   <= active_next;
            idx_reg      <= idx_next;
            ack_reg      <= ack_next;
            has_data_reg <= has_data_next;
            chk_reg      <= chk_next;
            m_valid_reg  <= m_valid_next;
            m_last_reg   <= m_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_byte_reg <= m_byte_next;
    end

    assign busy    = active_reg;
    assign m_valid = m_valid_reg;
    assign m_byte  = m_byte_reg;
    assign m_last  = m_last_reg;

endmodule

// File: rtl/framed_register_access_responder_unit.sv
// Framed register access responder. The parser steps its phase, count and
// running XOR check on each received byte as it is accepted. A frame is
// start, LEN (1 to MAX_DATA+1), command, data, XOR check, end. When the end
// byte of a frame arrives the command is decoded at once; a read issues a
// registered table read, a write updates the table in that same cycle. The
// reply (start, LEN, ack or nak code, four big-endian value bytes for reads,
// XOR check, end) leaves one byte per cycle through an output register while
// m_tready does not hold it off; a reply is 5 or 9 bytes long. The end byte
// of a following frame is held (s_tready low) until the reply generator has
// handed the last byte of the current reply to the output register; all other
// bytes are taken while a reply is going out. Both tables come out of reset
// reading zero through per-entry valid bits; ids outside a table read zero
// and ignore writes. Write the configuration registers only while no frame is
// in progress and no reply is pending.
// Depends on frar_pkg, frar_parser, frar_tables and frar_reply.
module framed_register_access_responder_unit #(
    parameter int MAX_DATA      = frar_pkg::MAX_DATA_DEF,
    parameter int PARAM_ENTRIES = frar_pkg::PARAM_ENTRIES_DEF,
    parameter int LIVE_ENTRIES  = frar_pkg::LIVE_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // Request stream of received bytes
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte

    // Reply stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] tx_byte
    output logic                          m_tlast,   // last_of_reply

    // Configuration write port
    input  logic                          cfg_wr_en,
    input  logic [frar_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [7:0]                    cfg_wr_data
);

    logic [7:0] start_reg;
    logic [7:0] end_reg;
    logic [7:0] ack_reg;
    logic [7:0] nak_reg;

    frar_pkg::rsp_req_t rsp_req;
    frar_pkg::tbl_req_t tbl_req;
    logic [31:0]        rd_data;
    logic               busy;

    // Configuration registers: take a write whenever the enable is high
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= frar_pkg::START_RST;
            end_reg   <= frar_pkg::END_RST;
            ack_reg   <= frar_pkg::ACK_RST;
            nak_reg   <= frar_pkg::NAK_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                frar_pkg::CFG_START: start_reg <= cfg_wr_data;
                frar_pkg::CFG_END:   end_reg   <= cfg_wr_data;
                frar_pkg::CFG_ACK:   ack_reg   <= cfg_wr_data;
                frar_pkg::CFG_NAK:   nak_reg   <= cfg_wr_data;
                default:             start_reg <= start_reg;
            endcase
        end
    end

    // Parse frames and decode commands
    frar_parser #(
        .MAX_DATA (MAX_DATA)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rx_valid   (s_tvalid),
        .rx_ready   (s_tready),
        .rx_byte    (s_tdata),
        .start_byte (start_reg),
        .end_byte   (end_reg),
        .busy       (busy),
        .rsp_req    (rsp_req),
        .tbl_req    (tbl_req)
    );

    // Hold the parameter and live words
    frar_tables #(
        .PARAM_ENTRIES (PARAM_ENTRIES),
        .LIVE_ENTRIES  (LIVE_ENTRIES)
    ) u_tables (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tbl_req (tbl_req),
        .rd_data (rd_data)
    );

    // Emit the reply frame byte by byte
    frar_reply u_reply (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rsp_req    (rsp_req),
        .rd_data    (rd_data),
        .start_byte (start_reg),
        .end_byte   (end_reg),
        .ack_code   (ack_reg),
        .nak_code   (nak_reg),
        .busy       (busy),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_byte     (m_tdata),
        .m_last     (m_tlast)
    );

endmodule

// File: tb/tb.sv
// Testbench of framed_register_access_responder_unit: drives byte requests,
// predicts every reply byte and checks it against the reply stream.
// Depends on frar_pkg and the RTL of the block; needs nothing else.
module tb;
    import frar_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          HOLD_CYCLES = 400;
    localparam int          RANDOM_BYTES = 60;
    localparam int          HIDX_W = $clog2(HEAD_DEPTH);
    localparam int          PIDX_W = $clog2(PARAM_ENTRIES_DEF);
    localparam int          LIDX_W = $clog2(LIVE_ENTRIES_DEF);

    // Settings walked through by the sweep, each packed {start, end, ack, nak};
    // the last one puts the reset values back.
    localparam logic [31:0] CFG_SWEEP [6] = '{
        32'h00FF_FF00, 32'hFF00_00FF, 32'h55AA_817E,
        32'h3C3C_1515, 32'hC381_7F80, 32'hAA55_0615
    };

    typedef enum logic [1:0] {HUNT, GET_LEN, GET_BODY} parse_ph_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       is_last;
    } reply_byte_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;       // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;            // [7:0] tx_byte
    logic                 m_tlast;            // last_of_reply
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [7:0]           cfg_wr_data = '0;

    framed_register_access_responder_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // Mirror of the block: configuration, parser state and both tables
    logic [7:0]  cfg_start = START_RST;
    logic [7:0]  cfg_end = END_RST;
    logic [7:0]  cfg_ack = ACK_RST;
    logic [7:0]  cfg_nak = NAK_RST;
    parse_ph_t   parse_ph = HUNT;
    logic [4:0]  rx_len = '0;
    logic [4:0]  body_cnt = '0;
    logic [7:0]  run_xor = '0;
    logic [7:0]  held_xor = '0;
    logic [7:0]  head_mirror [HEAD_DEPTH] = '{default: '0};
    logic [31:0] param_mirror [PARAM_ENTRIES_DEF] = '{default: '0};
    logic [31:0] live_mirror [LIVE_ENTRIES_DEF] = '{default: '0};

    reply_byte_t  expected_reply_q [$];
    logic [7:0]   frame_body_q [$];
    int unsigned  errors = 0;
    int unsigned  rx_sent = 0;
    int unsigned  cycle_cnt = 0;
    bit           idle_on = 1'b1;
    bit           stall_req = 1'b0;
    int           hold_left = 0;

    // Queue one whole reply frame: start, LEN, code, optional value, XOR, end
    function automatic void queue_reply(input logic [7:0] code, input bit has_word,
                                        input logic [31:0] word);
        logic [7:0] len;
        logic [7:0] chk;
        len = has_word ? LEN_READ : LEN_SHORT;
        chk = len ^ code;
        expected_reply_q.push_back('{cfg_start, 1'b0});
        expected_reply_q.push_back('{len, 1'b0});
        expected_reply_q.push_back('{code, 1'b0});
        if (has_word) begin
            for (int i = 3; i >= 0; i--) begin
                chk ^= word[8*i +: 8];
                expected_reply_q.push_back('{word[8*i +: 8], 1'b0});
            end
        end
        expected_reply_q.push_back('{chk, 1'b0});
        expected_reply_q.push_back('{cfg_end, 1'b1});
    endfunction

    // Advance the mirrored parser by one accepted byte and queue any reply
    function automatic void absorb_rx_byte(input logic [7:0] b);
        logic [4:0]  k;
        logic [7:0]  cmd;
        logic [7:0]  id;
        logic [31:0] word;
        case (parse_ph)
            GET_LEN: begin
                // a bad length drops back to hunting without a second look at b
                if (b == 8'd0 || b > MAX_DATA_DEF + 1) begin
                    parse_ph = HUNT;
                end else begin
                    rx_len = b[4:0];
                    body_cnt = '0;
                    run_xor = b;
                    parse_ph = GET_BODY;
                end
            end
            GET_BODY: begin
                k = body_cnt;
                body_cnt = k + 5'd1;
                if (k < rx_len) begin
                    if (k < HEAD_DEPTH) head_mirror[k[HIDX_W-1:0]] = b;
                    run_xor ^= b;
                end else if (k == rx_len) begin
                    held_xor = b;
                end else begin
                    parse_ph = HUNT;
                    // wrong end marker: drop the frame without a reply
                    if (b == cfg_end) begin
                        cmd = head_mirror[0];
                        id = head_mirror[1];
                        word = {head_mirror[2], head_mirror[3], head_mirror[4], head_mirror[5]};
                        if (held_xor != run_xor) begin
                            queue_reply(cfg_nak, 1'b0, '0);
                        end else if (cmd == CMD_RD_PARAM || cmd == CMD_RD_LIVE) begin
                            if (rx_len < MIN_RD_LEN) begin
                                queue_reply(cfg_nak, 1'b0, '0);
                            end else begin
                                word = '0;
                                if (cmd == CMD_RD_PARAM && id < PARAM_ENTRIES_DEF)
                                    word = param_mirror[id[PIDX_W-1:0]];
                                if (cmd == CMD_RD_LIVE && id < LIVE_ENTRIES_DEF)
                                    word = live_mirror[id[LIDX_W-1:0]];
                                queue_reply(cfg_ack, 1'b1, word);
                            end
                        end else if (cmd == CMD_WR_PARAM || cmd == CMD_WR_LIVE) begin
                            if (rx_len < MIN_WR_LEN) begin
                                queue_reply(cfg_nak, 1'b0, '0);
                            end else begin
                                // ids past the table end are acked but ignored
                                if (cmd == CMD_WR_PARAM && id < PARAM_ENTRIES_DEF)
                                    param_mirror[id[PIDX_W-1:0]] = word;
                                if (cmd == CMD_WR_LIVE && id < LIVE_ENTRIES_DEF)
                                    live_mirror[id[LIDX_W-1:0]] = word;
                                queue_reply(cfg_ack, 1'b0, '0);
                            end
                        end else begin
                            queue_reply(cfg_nak, 1'b0, '0);
                        end
                    end
                end
            end
            default: begin
                if (b == cfg_start) begin
                    body_cnt = '0;
                    parse_ph = GET_LEN;
                end
            end
        endcase
    endfunction

    function automatic void flag_mismatch(input string what, input reply_byte_t want);
        errors++;
        if (errors <= 10)
            $display("tb: %s: expected byte %02h last %0b, got byte %02h last %0b",
                     what, want.tx_byte, want.is_last, m_tdata, m_tlast);
    endfunction

    // Reply checker: compare every accepted reply byte with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reply_q.size() == 0) begin
                flag_mismatch("reply byte with none pending", '0);
            end else if (m_tdata !== expected_reply_q[0].tx_byte ||
                         m_tlast !== expected_reply_q[0].is_last) begin
                flag_mismatch("reply byte mismatch", expected_reply_q.pop_front());
            end else begin
                void'(expected_reply_q.pop_front());
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here on request
    always @(posedge aclk) begin
        if (stall_req) begin
            hold_left = HOLD_CYCLES;
            stall_req = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !idle_on || ($urandom_range(0, 99) >= 24);
        end
    end

    // Watchdog: end the run if it hangs
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Offer one byte request, with a random gap first while idle_on is set, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        if (idle_on) begin
            while ($urandom_range(0, 99) < 24) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        rx_sent++;
        absorb_rx_byte(b);
    endtask

    // Send start, LEN, cmd, frame_body_q, XOR check and end marker
    task automatic send_frame(input logic [7:0] cmd, input bit bad_chk, input bit bad_end);
        logic [7:0] len;
        logic [7:0] chk;
        logic [7:0] stop;
        len = 8'(frame_body_q.size() + 1);
        chk = len ^ cmd;
        foreach (frame_body_q[i]) chk ^= frame_body_q[i];
        if (bad_chk) chk ^= 8'($urandom_range(1, 255));
        stop = bad_end ? cfg_end ^ 8'($urandom_range(1, 255)) : cfg_end;
        send_byte(cfg_start);
        send_byte(len);
        send_byte(cmd);
        foreach (frame_body_q[i]) send_byte(frame_body_q[i]);
        send_byte(chk);
        send_byte(stop);
    endtask

    // Table access frame: body is id, value big-endian, then filler, cut to nbody
    task automatic send_access(input logic [7:0] cmd, input logic [7:0] id,
                               input logic [31:0] word, input int nbody,
                               input bit bad_chk, input bit bad_end);
        frame_body_q.delete();
        for (int i = 0; i < nbody; i++) begin
            if (i == 0) frame_body_q.push_back(id);
            else if (i < 5) frame_body_q.push_back(word[8*(4-i) +: 8]);
            else frame_body_q.push_back(8'($urandom_range(0, 255)));
        end
        send_frame(cmd, bad_chk, bad_end);
    endtask

    // Drop valid, wait for every pending reply byte, then let the block settle
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (expected_reply_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Feed filler until the parser is back to hunting for a start marker
    task automatic flush_parser();
        while (parse_ph != HUNT) send_byte(~cfg_end);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= v;
        @(posedge aclk);
        case (idx)
            CFG_START: cfg_start = v;
            CFG_END:   cfg_end = v;
            CFG_ACK:   cfg_ack = v;
            default:   cfg_nak = v;
        endcase
    endtask

    // Reprogram all four registers with the block idle
    task automatic apply_config(input logic [31:0] setting);
        flush_parser();
        wait_quiet();
        write_reg(CFG_START, setting[31:24]);
        write_reg(CFG_END, setting[23:16]);
        write_reg(CFG_ACK, setting[15:8]);
        write_reg(CFG_NAK, setting[7:0]);
        cfg_wr_en <= 1'b0;
    endtask

    // One random frame: mostly well-formed accesses, some noise and broken frames
    task automatic send_random_frame();
        int          r;
        int          nb;
        logic [7:0]  cmd;
        logic [7:0]  id;
        logic [31:0] word;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else if (r < 12) begin
            send_byte(cfg_start);
            send_byte($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(MAX_DATA_DEF + 2, 255)));
        end else begin
            case ($urandom_range(0, 3))
                0: cmd = CMD_RD_PARAM;
                1: cmd = CMD_WR_PARAM;
                2: cmd = CMD_RD_LIVE;
                default: cmd = CMD_WR_LIVE;
            endcase
            if ($urandom_range(0, 99) < 12) cmd = 8'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            id = (r < 70) ? 8'($urandom_range(0, 7)) :
                 (r < 90) ? 8'($urandom_range(0, 63)) : 8'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            word = (r < 10) ? 32'h0 : (r < 20) ? 32'hFFFF_FFFF : $urandom;
            // hold to the length the command needs, with some short and long frames
            if (cmd == CMD_RD_PARAM || cmd == CMD_RD_LIVE) nb = 1;
            else if (cmd == CMD_WR_PARAM || cmd == CMD_WR_LIVE) nb = 5;
            else nb = $urandom_range(0, 5);
            if ($urandom_range(0, 99) < 15) nb = $urandom_range(0, MAX_DATA_DEF);
            send_access(cmd, id, word, nb, $urandom_range(0, 99) < 5,
                        $urandom_range(0, 99) < 5);
        end
    endtask

    // Every command, table edges, short and long frames, bad length, check and end
    task automatic test_directed_access();
        send_access(CMD_WR_PARAM, 8'd0, 32'hFFFF_FFFF, 5, 1'b0, 1'b0);
        send_access(CMD_RD_PARAM, 8'd0, 32'h0, 1, 1'b0, 1'b0);
        send_access(CMD_WR_LIVE, 8'd63, 32'h8000_0001, 5, 1'b0, 1'b0);
        send_access(CMD_RD_LIVE, 8'd63, 32'h0, 1, 1'b0, 1'b0);
        send_access(CMD_WR_PARAM, 8'hFF, 32'h1234_5678, 5, 1'b0, 1'b0);
        send_access(CMD_RD_PARAM, 8'hFF, 32'h0, 1, 1'b0, 1'b0);
        send_access(CMD_RD_LIVE, 8'd64, 32'h0, 1, 1'b0, 1'b0);
        send_access(CMD_RD_PARAM, 8'd0, 32'h0, 0, 1'b0, 1'b0);
        send_access(CMD_WR_LIVE, 8'd1, 32'hA5A5_5A5A, 4, 1'b0, 1'b0);
        send_access(8'h00, 8'd0, 32'h0, 0, 1'b0, 1'b0);
        send_access(8'hFF, 8'd3, 32'hDEAD_BEEF, MAX_DATA_DEF, 1'b0, 1'b0);
        send_access(CMD_RD_LIVE, 8'd63, 32'h0, MAX_DATA_DEF, 1'b0, 1'b0);
        send_access(CMD_WR_PARAM, 8'd2, 32'h0102_0304, 5, 1'b1, 1'b0);
        send_access(CMD_WR_PARAM, 8'd2, 32'h0102_0304, 5, 1'b0, 1'b1);
        send_byte(cfg_start);
        send_byte(8'd0);
        send_byte(cfg_start);
        send_byte(8'(MAX_DATA_DEF + 2));
        send_byte(8'hFF);
        send_access(CMD_RD_PARAM, 8'd2, 32'h0, 1, 1'b0, 1'b0);
        wait_quiet();
    endtask

    // Walk the registers through extreme and odd settings, traffic under each
    task automatic test_config_sweep();
        foreach (CFG_SWEEP[i]) begin
            apply_config(CFG_SWEEP[i]);
            send_access(CMD_WR_LIVE, 8'd5, $urandom, 5, 1'b0, 1'b0);
            send_access(CMD_RD_LIVE, 8'd5, 32'h0, 1, 1'b0, 1'b0);
            repeat (1) send_random_frame();
        end
        flush_parser();
        wait_quiet();
    endtask

    // Bulk random traffic; the middle part runs with no idling on either side
    task automatic test_random_traffic();
        int unsigned base;
        base = rx_sent;
        while (rx_sent - base < RANDOM_BYTES) begin
            idle_on = !((rx_sent - base) >= 10 && (rx_sent - base) < 50);
            send_random_frame();
        end
        idle_on = 1'b1;
        wait_quiet();
    endtask

    // Hold the reply side off for a long stretch while frames keep coming
    task automatic test_output_backpressure();
        stall_req = 1'b1;
        repeat (2) begin
            send_access(CMD_RD_PARAM, 8'($urandom_range(0, 7)), 32'h0, 1, 1'b0, 1'b0);
            send_access(CMD_WR_LIVE, 8'($urandom_range(0, 7)), $urandom, 5, 1'b0, 1'b0);
        end
        wait_quiet();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_access();
        test_config_sweep();
        test_random_traffic();
        test_output_backpressure();
        wait_quiet();
        if (expected_reply_q.size() != 0) errors++;
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
